>>> design/bcdns_pkg.sv
// Shared widths, constants, stage types and the month table for the BCD-to-nanoseconds pipe.
`default_nettype none

package bcdns_pkg;

  // Port and field widths
  localparam int unsigned DATE_W = 24;
  localparam int unsigned TIME_W = 23;
  localparam int unsigned SS_W   = 16;
  localparam int unsigned PRE_W  = 15;
  localparam int unsigned NS_W   = 55;

  // Internal widths
  localparam int unsigned MONTH_W = 5;   // tens*10 + units, up to 25
  localparam int unsigned DAY_W   = 6;   // up to 45
  localparam int unsigned MIDX_W  = 4;
  localparam int unsigned DAYS_W  = 9;   // up to 379 days into the year
  localparam int unsigned TOD_W   = 18;  // up to 210385 s with non-decimal digits
  localparam int unsigned SECS_W  = 26;
  localparam int unsigned DIV_W   = PRE_W + 1;  // prescaler + 1, up to 32768
  localparam int unsigned REM_W   = PRE_W;      // remainder stays below divisor
  localparam int unsigned QUO_W   = 30;         // fraction stays below 1e9
  localparam int unsigned NUM_W   = REM_W + QUO_W;

  // Pipeline depth: decode, multiply, scale, one divider stage per quotient bit, output
  localparam int unsigned DIV_STAGES   = QUO_W;
  localparam int unsigned PIPE_LATENCY = DIV_STAGES + 4;

  localparam logic [PRE_W-1:0]  PRESCALER_RESET = 15'd1023;
  localparam logic [QUO_W-1:0]  NS_PER_SEC      = 30'd1000000000;
  localparam logic [16:0]       SECS_PER_DAY    = 17'd86400;
  localparam logic [MONTH_W-1:0] MONTH_MIN      = 5'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX      = 5'd12;

  // Sideband that rides along with the divider
  typedef struct packed {
    logic            valid;
    logic            bad_month;
    logic            bad_sub;
    logic [NS_W-1:0] secs_ns;
  } tag_t;

  // One divider stage: partial remainder, numerator bits shifting out, quotient shifting in
  typedef struct packed {
    tag_t             tag;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] nq;
  } div_stage_t;

  // Days lost against 32-day months before the start of each month (leap year)
  function automatic logic [4:0] month_shortfall(input logic [MIDX_W-1:0] mi);
    logic [4:0] s;
    case (mi)
      4'd0:    s = 5'd0;
      4'd1:    s = 5'd1;
      4'd2:    s = 5'd4;
      4'd3:    s = 5'd5;
      4'd4:    s = 5'd7;
      4'd5:    s = 5'd8;
      4'd6:    s = 5'd10;
      4'd7:    s = 5'd11;
      4'd8:    s = 5'd12;
      4'd9:    s = 5'd14;
      4'd10:   s = 5'd15;
      4'd11:   s = 5'd17;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/bcd_calendar_to_nanoseconds.sv
// Top level: BCD date/time snapshot plus subsecond count to nanoseconds since start of year.
//
//  channel   ports                                            handshake
//  --------  -----------------------------------------------  ---------------------------
//  input     date_word_i, time_word_i, subsecond_count_i      start & !busy
//  result    time_ns_o, month_invalid_o, subsecond_invalid_o  done_o, one cycle, no stall
//  config    cfg_wdata_i (sync_prescaler)                     cfg_we_i
//
// One beat is taken every cycle; busy stays low. Each result passes through decode, two
// multiply stages, 30 divider stages (one quotient bit each, set by the fraction division)
// and the output register.
// Reset clears all valid bits and loads the prescaler with 1023.
// The receiver cannot stall; results leave in input order.
`default_nettype none

module bcd_calendar_to_nanoseconds (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [bcdns_pkg::DATE_W-1:0]  date_word_i,
  input  wire logic [bcdns_pkg::TIME_W-1:0]  time_word_i,
  input  wire logic [bcdns_pkg::SS_W-1:0]    subsecond_count_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bcdns_pkg::PRE_W-1:0]   cfg_wdata_i,
  output      logic                          done_o,
  output      logic [bcdns_pkg::NS_W-1:0]    time_ns_o,
  output      logic                          month_invalid_o,
  output      logic                          subsecond_invalid_o
);
  import bcdns_pkg::*;

  // Prescaler register
  logic [PRE_W-1:0] prescaler_q;
  logic [DIV_W-1:0] divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q <= PRESCALER_RESET;
    end else if (cfg_we_i) begin
      prescaler_q <= cfg_wdata_i;
    end
  end

  assign divisor = {1'b0, prescaler_q} + DIV_W'(1);
  assign busy    = 1'b0;

  // Stage 1: BCD decode, day count, time of day, subsecond difference
  logic               accept;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [DAY_W-1:0]   day_idx;
  logic [MIDX_W-1:0]  mi;
  logic [DAYS_W:0]    days_wide;
  logic               bad_month_d;
  logic               bad_sub_d;
  logic [DAYS_W-1:0]  days_d;
  logic [TOD_W-1:0]   tod_d;
  logic [PRE_W-1:0]   diff_d;

  assign accept = start & ~busy;

  always_comb begin
    month = (date_word_i[12] ? MONTH_W'(10) : MONTH_W'(0)) + MONTH_W'(date_word_i[11:8]);
    day   = DAY_W'(date_word_i[5:4]) * DAY_W'(10) + DAY_W'(date_word_i[3:0]);
    bad_month_d = (month < MONTH_MIN) || (month > MONTH_MAX);
    mi        = MIDX_W'(month - MONTH_MIN);
    day_idx   = (day == '0) ? '0 : day - DAY_W'(1);
    days_wide = (DAYS_W+1)'(day_idx) + ((DAYS_W+1)'(mi) << 5)
              - (DAYS_W+1)'(month_shortfall(mi));
    days_d    = bad_month_d ? '0 : days_wide[DAYS_W-1:0];

    tod_d = (time_word_i[22] ? TOD_W'(43200) : TOD_W'(0))
          + TOD_W'(time_word_i[21:20]) * TOD_W'(36000)
          + TOD_W'(time_word_i[19:16]) * TOD_W'(3600)
          + TOD_W'(time_word_i[14:12]) * TOD_W'(600)
          + TOD_W'(time_word_i[11:8])  * TOD_W'(60)
          + TOD_W'(time_word_i[6:4])   * TOD_W'(10)
          + TOD_W'(time_word_i[3:0]);

    bad_sub_d = subsecond_count_i > {1'b0, prescaler_q};
    diff_d    = bad_sub_d ? '0 : prescaler_q - subsecond_count_i[PRE_W-1:0];
  end

  logic              s1_valid_q;
  logic              s1_bad_month_q;
  logic              s1_bad_sub_q;
  logic [DAYS_W-1:0] s1_days_q;
  logic [TOD_W-1:0]  s1_tod_q;
  logic [PRE_W-1:0]  s1_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bad_month_q <= bad_month_d;
    s1_bad_sub_q   <= bad_sub_d;
    s1_days_q      <= days_d;
    s1_tod_q       <= tod_d;
    s1_diff_q      <= diff_d;
  end

  // Stage 2: whole seconds and fraction numerator
  logic              s2_valid_q;
  logic              s2_bad_month_q;
  logic              s2_bad_sub_q;
  logic [SECS_W-1:0] s2_secs_q;
  logic [NUM_W-1:0]  s2_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_bad_month_q <= s1_bad_month_q;
    s2_bad_sub_q   <= s1_bad_sub_q;
    s2_secs_q      <= SECS_W'(s1_days_q) * SECS_W'(SECS_PER_DAY) + SECS_W'(s1_tod_q);
    s2_num_q       <= NUM_W'(s1_diff_q) * NUM_W'(NS_PER_SEC);
  end

  // Stage 3: whole seconds to nanoseconds, load the divider
  div_stage_t s3_q;
  div_stage_t div_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q.tag.valid     <= s2_valid_q;
      s3_q.tag.bad_month <= s2_bad_month_q;
      s3_q.tag.bad_sub   <= s2_bad_sub_q;
      s3_q.tag.secs_ns   <= NS_W'(s2_secs_q) * NS_W'(NS_PER_SEC);
      s3_q.rem           <= s2_num_q[NUM_W-1:QUO_W];
      s3_q.nq            <= s2_num_q[QUO_W-1:0];
    end
  end

  // Fraction divider
  bcdns_div_pipe u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divisor_i (divisor),
    .in_i      (s3_q),
    .out_o     (div_out)
  );

  // Output register: add the fraction, zero on a bad month
  logic            done_q;
  logic [NS_W-1:0] time_ns_q;
  logic            month_invalid_q;
  logic            subsecond_invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_out.tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    time_ns_q           <= div_out.tag.bad_month ? '0
                         : div_out.tag.secs_ns + NS_W'(div_out.nq);
    month_invalid_q     <= div_out.tag.bad_month;
    subsecond_invalid_q <= div_out.tag.bad_sub;
  end

  assign done_o              = done_q;
  assign time_ns_o           = time_ns_q;
  assign month_invalid_o     = month_invalid_q;
  assign subsecond_invalid_o = subsecond_invalid_q;

  // Checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_LATENCY done_o)
    else $error("accepted beat did not complete after pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_LATENCY))
    else $error("result beat without matching input beat");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_out.tag.valid |-> (div_out.nq < NS_PER_SEC))
    else $error("fraction quotient reached one second");

  a_bad_month_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && month_invalid_o) |-> (time_ns_o == '0))
    else $error("invalid month gave a nonzero time");

endmodule

`default_nettype wire

>>> design/bcdns_div_pipe.sv
// Pipelined restoring divider: one quotient bit per register stage, sideband carried along.
`default_nettype none

module bcdns_div_pipe (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [bcdns_pkg::DIV_W-1:0]  divisor_i,
  input  wire bcdns_pkg::div_stage_t        in_i,
  output      bcdns_pkg::div_stage_t        out_o
);
  import bcdns_pkg::*;

  div_stage_t prev_w [DIV_STAGES];
  div_stage_t st_d   [DIV_STAGES];
  div_stage_t st_q   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_W-1:0] trial;
    logic             ge;

    // chain input
    if (k == 0) begin : g_first
      assign prev_w[k] = in_i;
    end else begin : g_next
      assign prev_w[k] = st_q[k-1];
    end

    // bring down the next numerator bit, subtract if it fits
    always_comb begin
      trial          = {prev_w[k].rem, prev_w[k].nq[QUO_W-1]};
      ge             = (trial >= divisor_i);
      st_d[k].tag    = prev_w[k].tag;
      st_d[k].rem    = ge ? REM_W'(trial - divisor_i) : trial[REM_W-1:0];
      st_d[k].nq     = {prev_w[k].nq[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k] <= '0;
      end else begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_o = st_q[DIV_STAGES-1];

endmodule

`default_nettype wire
